>>> rtl/lsma_pkg.sv
// ----------------------------------------------------------------------------
// lsma_pkg: shared definitions for the light sensor moving average
// Sizes of the sample ring, field widths, register indexes and the ring
// write request that passes between the datapath and the ring storage.
// ----------------------------------------------------------------------------
`default_nettype none

package lsma_pkg;

  // Block parameters
  localparam int unsigned READINGS          = 16;
  localparam int unsigned ANALOG_RANGE      = 1023;
  localparam int unsigned MAX_LIGHT_READING = 1023;

  // Field widths fixed by the interface
  localparam int unsigned RAW_W = 10;
  localparam int unsigned OUT_W = 14;
  localparam int unsigned OFF_W = 11;
  localparam int unsigned FIX_W = 10;

  // Derived widths
  localparam int unsigned SAMP_W    = $clog2(ANALOG_RANGE + 1);
  localparam int unsigned SLOT_W    = $clog2(READINGS);
  localparam int unsigned TOP_VALUE = ANALOG_RANGE * READINGS;
  localparam int unsigned TOT_W     = $clog2(TOP_VALUE + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED    = 2'd3;

  // Ring write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [SAMP_W-1:0] data;
  } ring_wr_t;

endpackage

`default_nettype wire

>>> rtl/lsma_ring.sv
// ----------------------------------------------------------------------------
// lsma_ring: sample ring storage
// Synchronous memory with registered read; per-entry valid flops
// make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lsma_ring (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [lsma_pkg::SLOT_W-1:0]   rd_slot_i,
  input  wire lsma_pkg::ring_wr_t            wr_i,
  output logic      [lsma_pkg::SAMP_W-1:0]   rd_data_o
);

  logic [lsma_pkg::SAMP_W-1:0]   mem_q [lsma_pkg::READINGS];
  logic [lsma_pkg::SAMP_W-1:0]   rd_q;
  logic [lsma_pkg::READINGS-1:0] vld_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.slot] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_slot_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.slot] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_slot_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/light_sensor_moving_average.sv
// ----------------------------------------------------------------------------
// light_sensor_moving_average: boxcar average of light-sensor samples
// Rescales each raw sample, replaces the oldest ring entry, keeps a running
// total; returns brightness in units of 1/READINGS, offset and clamped if adaptive.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  -------   ---  -------------------------  -------------------------
//  input     in   in_valid_i / in_stall_o    raw_sample_i [9:0]
//  output    out  out_valid_o / out_stall_i  brightness_scaled_o [13:0]
//  config    in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  One sample per cycle sustained while the output is not stalled. Stage 0
//  issues the ring read on input transfer; stage 1 then does the
//  read-modify-write of the ring entry and the running total and loads the
//  output register. The ring takes one read and one write per cycle.
//  Reset clears the ring (via per-entry valid flops), total and write slot.
//  A stalled output holds the result; the input stalls only when both the
//  read stage and the output register are full and the output is stalled.
//
`default_nettype none

module light_sensor_moving_average (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [lsma_pkg::RAW_W-1:0]       raw_sample_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [lsma_pkg::OUT_W-1:0]       brightness_scaled_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lsma_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lsma_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned X_W    = (lsma_pkg::SAMP_W > lsma_pkg::RAW_W) ?
                                   lsma_pkg::SAMP_W : lsma_pkg::RAW_W;
  localparam int unsigned PROD_W = X_W + lsma_pkg::SAMP_W;
  localparam int unsigned FX_W   = (lsma_pkg::SAMP_W > lsma_pkg::FIX_W) ?
                                   lsma_pkg::SAMP_W : lsma_pkg::FIX_W;
  localparam int unsigned SUM_W  = lsma_pkg::TOT_W + lsma_pkg::SLOT_W +
                                   lsma_pkg::OFF_W + 2;

  // Rescale x*A/D as x*(A*M) >> S with M = ceil(2^S/D); exact for every
  // product x*A below 2^PROD_W.
  localparam int unsigned     DIV_S = PROD_W + $clog2(lsma_pkg::MAX_LIGHT_READING);
  localparam longint unsigned DIV_M = ((64'd1 << DIV_S) +
                                       64'(lsma_pkg::MAX_LIGHT_READING) - 64'd1) /
                                      64'(lsma_pkg::MAX_LIGHT_READING);
  localparam longint unsigned DIV_C = DIV_M * 64'(lsma_pkg::ANALOG_RANGE);
  localparam int unsigned     C_W   = $clog2(DIV_C + 64'd1);
  localparam int unsigned     MUL_W = X_W + C_W;

  localparam logic [lsma_pkg::TOT_W-1:0] TOP_T   = lsma_pkg::TOT_W'(lsma_pkg::TOP_VALUE);
  localparam logic signed [SUM_W-1:0]    TOP_S   = SUM_W'(lsma_pkg::TOP_VALUE);
  localparam logic signed [SUM_W-1:0]    READ_S  = SUM_W'(lsma_pkg::READINGS);
  localparam logic [lsma_pkg::SLOT_W-1:0] LAST_SLOT = lsma_pkg::SLOT_W'(lsma_pkg::READINGS - 1);

  // Configuration registers
  logic                           adaptive_q;
  logic                           force_q;
  logic [lsma_pkg::OFF_W-1:0]     offset_q;
  logic [lsma_pkg::FIX_W-1:0]     fixed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adaptive_q <= 1'b1;
      force_q    <= 1'b0;
      offset_q   <= '0;
      fixed_q    <= lsma_pkg::FIX_W'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsma_pkg::REG_ADAPTIVE: adaptive_q <= cfg_data_i[0];
        lsma_pkg::REG_FORCE:    force_q    <= cfg_data_i[0];
        lsma_pkg::REG_OFFSET:   offset_q   <= cfg_data_i[lsma_pkg::OFF_W-1:0];
        lsma_pkg::REG_FIXED:    fixed_q    <= cfg_data_i[lsma_pkg::FIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_xfer;
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Stage 0: rescale and saturate, issue ring read
  logic [X_W-1:0]              x_sel;
  logic [MUL_W-1:0]            mul;
  logic [MUL_W-1:0]            quot;
  logic [lsma_pkg::SAMP_W-1:0] v0;

  assign x_sel = force_q ? X_W'(lsma_pkg::ANALOG_RANGE) : X_W'(raw_sample_i);
  assign mul   = MUL_W'(x_sel) * MUL_W'(DIV_C);
  assign quot  = mul >> DIV_S;
  assign v0    = (quot > MUL_W'(lsma_pkg::ANALOG_RANGE)) ?
                 lsma_pkg::SAMP_W'(lsma_pkg::ANALOG_RANGE) : quot[lsma_pkg::SAMP_W-1:0];

  logic [lsma_pkg::SLOT_W-1:0] slot_q;
  logic [lsma_pkg::SLOT_W-1:0] s1_slot_q;
  logic [lsma_pkg::SAMP_W-1:0] s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_slot_q <= slot_q;
      s1_v_q    <= v0;
    end
  end

  // Ring storage: consecutive transfers always hit different slots, so the
  // read of the next item never collides with the pending write-back.
  lsma_pkg::ring_wr_t          ring_wr;
  logic [lsma_pkg::SAMP_W-1:0] old_v;

  assign ring_wr.en   = s1_adv;
  assign ring_wr.slot = s1_slot_q;
  assign ring_wr.data = s1_v_q;

  lsma_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_slot_i (slot_q),
    .wr_i      (ring_wr),
    .rd_data_o (old_v)
  );

  // Stage 1: running total update and output mapping
  logic [lsma_pkg::TOT_W-1:0] total_q;
  logic [lsma_pkg::TOT_W-1:0] total_d;

  assign total_d = total_q - lsma_pkg::TOT_W'(old_v) + lsma_pkg::TOT_W'(s1_v_q);

  logic signed [SUM_W-1:0]    tot_s;
  logic signed [SUM_W-1:0]    off_s;
  logic signed [SUM_W-1:0]    sum_s;
  logic [lsma_pkg::TOT_W-1:0] adapt_res;
  logic [FX_W-1:0]            fix_sat;
  logic [lsma_pkg::TOT_W-1:0] fix_res;
  logic [lsma_pkg::TOT_W-1:0] res;

  assign tot_s = SUM_W'(total_d);
  assign off_s = {{(SUM_W - lsma_pkg::OFF_W){offset_q[lsma_pkg::OFF_W-1]}}, offset_q};
  assign sum_s = tot_s + off_s * READ_S;

  always_comb begin
    if (sum_s < 0) begin
      adapt_res = '0;
    end else if (sum_s > TOP_S) begin
      adapt_res = TOP_T;
    end else begin
      adapt_res = sum_s[lsma_pkg::TOT_W-1:0];
    end
  end

  assign fix_sat = (FX_W'(fixed_q) > FX_W'(lsma_pkg::ANALOG_RANGE)) ?
                   FX_W'(lsma_pkg::ANALOG_RANGE) : FX_W'(fixed_q);
  assign fix_res = lsma_pkg::TOT_W'(fix_sat) * lsma_pkg::TOT_W'(lsma_pkg::READINGS);

  always_comb begin
    if (adaptive_q) begin
      res = adapt_res;
    end else if (force_q) begin
      res = TOP_T;
    end else begin
      res = fix_res;
    end
  end

  logic [lsma_pkg::OUT_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= lsma_pkg::OUT_W'(res);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign brightness_scaled_o = out_q;

  // Assertions
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOP_T)
    else $error("running total above full scale");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_SLOT)
    else $error("write slot out of range");

  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted transfer lost before ring stage");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && total_q == $past(total_d)))
    else $error("ring stage advance did not load output and total");

endmodule

`default_nettype wire
